/* sv/dfb_pkg.sv */
// ----------------------------------------------------------------------------
// dfb_pkg
// shared types and constants of the decimating framebuffer blitter
// ----------------------------------------------------------------------------
package dfb_pkg;

  // side lengths, counters and steps are 12 bits wide
  localparam int SIDE_W   = 12;
  localparam int WIDE_W   = SIDE_W + 1;
  localparam int INDEX_W  = 2 * SIDE_W;
  localparam int CHANNELS = 3;
  localparam int LANES    = 4;
  localparam int LANE_W   = 2;

  localparam int CFG_DATA_W  = 24;
  localparam int CFG_INDEX_W = 3;

  localparam int QUEUE_DEPTH_DEFAULT = 4;

  typedef logic [SIDE_W-1:0] side_t;
  typedef logic [WIDE_W-1:0] wide_t;

  localparam side_t SIDE_ONE = side_t'(1);
  // largest step the fit search may reach
  localparam side_t MAX_STEP = side_t'(4095);

  localparam logic [2:0] BPP_MIN = 3'd3;
  localparam logic [2:0] BPP_MAX = 3'd4;

  // item commands
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  // register indexes of the write port
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_AUTO_FIT,
    CFG_SOURCE_SIZE,
    CFG_BYTES_PER_PIXEL,
    CFG_SCREEN_SIZE,
    CFG_MANUAL_SCALE,
    CFG_MANUAL_ORIGIN,
    CFG_CHANNEL_LANES
  } cfg_index_e;

  // frame setup sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIT_W,
    ST_FIT_H,
    ST_KEEP_W,
    ST_KEEP_H
  } setup_state_t;

  typedef struct packed {
    logic                   auto_fit;
    logic [INDEX_W-1:0]     source_size;
    logic [2:0]             bytes_per_pixel;
    logic [INDEX_W-1:0]     screen_size;
    logic [INDEX_W-1:0]     manual_scale;
    logic [INDEX_W-1:0]     manual_origin;
    logic [CHANNELS*LANE_W-1:0] channel_lanes;
  } cfg_t;

  typedef struct packed {
    logic       command;
    logic [7:0] source_byte;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0] word_index;
    logic [31:0]        write_data;
    logic [LANES-1:0]   byte_enable;
  } out_item_t;

  // one kept on-screen pixel, queued between front and back
  typedef struct packed {
    side_t                     x;
    side_t                     y;
    logic [CHANNELS-1:0][7:0]  channel;
  } job_t;

  typedef struct packed {
    logic busy;
    logic push;
  } front_status_t;

endpackage

/* sv/dfb_divider.sv */
// ----------------------------------------------------------------------------
// dfb_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module dfb_divider (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  dfb_pkg::side_t dividend,
  input  dfb_pkg::wide_t divisor,
  output logic          busy,
  output logic          done,
  output dfb_pkg::side_t quotient
);
  import dfb_pkg::*;

  localparam int CNT_W = $clog2(SIDE_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SIDE_W - 1);

  logic [CNT_W-1:0] count;
  wide_t            rem;
  wide_t            dvs;
  side_t            dvd;
  side_t            quo;
  wide_t            trial;
  logic             take;
  wide_t            rem_next;

  // remainder stays below the divisor, so its low bits hold it
  assign trial    = {rem[SIDE_W-1:0], dvd[SIDE_W-1]};
  assign take     = trial >= dvs;
  assign rem_next = take ? trial - dvs : trial;
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
      end else if (busy && count == CNT_LAST) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      count <= '0;
      rem   <= '0;
      dvd   <= dividend;
      dvs   <= divisor;
    end else if (busy) begin
      count <= count + CNT_W'(1);
      rem   <= rem_next;
      dvd   <= {dvd[SIDE_W-2:0], 1'b0};
      quo   <= {quo[SIDE_W-2:0], take};
    end
  end

endmodule

/* sv/dfb_front.sv */
// ----------------------------------------------------------------------------
// dfb_front
// accepts items, runs frame setup, tracks raster position, picks kept pixels
// ----------------------------------------------------------------------------
module dfb_front (
  input  logic                  clk,
  input  logic                  rst,
  input  dfb_pkg::cfg_t         cfg,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  dfb_pkg::in_item_t     item,
  input  logic                  queue_full,
  output dfb_pkg::front_status_t status,
  output dfb_pkg::job_t         job
);
  import dfb_pkg::*;

  localparam logic [1:0] BYTE_FIRST  = 2'd0;
  localparam logic [1:0] BYTE_SECOND = 2'd1;
  localparam logic [1:0] BYTE_THIRD  = 2'd2;

  setup_state_t state, state_next;

  // raster position
  logic [1:0] byte_in_pixel;
  side_t      source_column, source_row;
  side_t      col_phase, col_quot, row_phase, row_quot;
  logic [15:0] held_bytes;

  // frame parameters
  side_t step_x, step_y, origin_x, origin_y, kept_columns, kept_rows;

  // setup operands, captured at start
  side_t snap_sw, snap_sh, snap_dw, snap_dh;
  logic  snap_auto;
  side_t fit_q;

  side_t sw, sh, dw, dh;
  side_t scale_x, scale_y;
  logic  accept, start_go, data_go;
  logic [2:0] bpp_eff;
  logic [2:0] byte_inc;
  logic  pixel_end, row_end;
  wide_t col_inc;
  side_t col_phase_inc, row_phase_inc;
  wide_t x_sum, y_sum;
  logic  keep;

  logic  div_start, div_busy, div_done;
  side_t div_dividend, div_quotient;
  wide_t div_divisor;
  side_t fit_max, fit_step;
  side_t half_d, half_k, centered;

  assign sw = cfg.source_size[SIDE_W-1:0];
  assign sh = cfg.source_size[INDEX_W-1:SIDE_W];
  assign dw = cfg.screen_size[SIDE_W-1:0];
  assign dh = cfg.screen_size[INDEX_W-1:SIDE_W];
  assign scale_x = cfg.manual_scale[SIDE_W-1:0];
  assign scale_y = cfg.manual_scale[INDEX_W-1:SIDE_W];

  assign item_stall = (state != ST_IDLE) || queue_full;
  assign accept     = item_valid && !item_stall;
  assign start_go   = accept && (item.command == CMD_START);
  assign data_go    = accept && (item.command == CMD_DATA) && (source_row < sh);

  always_comb begin
    if (cfg.bytes_per_pixel < BPP_MIN) begin
      bpp_eff = BPP_MIN;
    end else if (cfg.bytes_per_pixel > BPP_MAX) begin
      bpp_eff = BPP_MAX;
    end else begin
      bpp_eff = cfg.bytes_per_pixel;
    end
  end

  assign byte_inc  = {1'b0, byte_in_pixel} + 3'd1;
  assign pixel_end = byte_inc >= bpp_eff;
  assign col_inc   = {1'b0, source_column} + WIDE_W'(1);
  assign row_end   = col_inc >= {1'b0, sw};
  assign col_phase_inc = col_phase + SIDE_ONE;
  assign row_phase_inc = row_phase + SIDE_ONE;

  // destination of the current pixel, valid when both phases are zero
  assign x_sum = {1'b0, col_quot} + {1'b0, origin_x};
  assign y_sum = {1'b0, row_quot} + {1'b0, origin_y};
  assign keep  = (byte_in_pixel == BYTE_THIRD) && (col_phase == '0) && (row_phase == '0) &&
                 (col_quot < kept_columns) && (row_quot < kept_rows) &&
                 (x_sum < {1'b0, dw}) && (y_sum < {1'b0, dh});

  assign status.push = data_go && keep;
  assign status.busy = state != ST_IDLE;

  assign job.x       = x_sum[SIDE_W-1:0];
  assign job.y       = y_sum[SIDE_W-1:0];
  assign job.channel = {item.source_byte, held_bytes[15:8], held_bytes[7:0]};

  // ---- setup sequencer ----

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start_go) begin
          state_next = cfg.auto_fit ? ST_FIT_W : ST_KEEP_W;
        end
      end
      ST_FIT_W: begin
        if (div_done) state_next = ST_FIT_H;
      end
      ST_FIT_H: begin
        if (div_done) state_next = ST_KEEP_W;
      end
      ST_KEEP_W: begin
        if (div_done) state_next = ST_KEEP_H;
      end
      ST_KEEP_H: begin
        if (div_done) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    div_start    = (state != ST_IDLE) && !div_busy && !div_done;
    div_dividend = '0;
    div_divisor  = WIDE_W'(1);
    half_d       = '0;
    case (state)
      ST_FIT_W: begin
        div_dividend = snap_sw;
        div_divisor  = {1'b0, snap_dw} + WIDE_W'(1);
      end
      ST_FIT_H: begin
        div_dividend = snap_sh;
        div_divisor  = {1'b0, snap_dh} + WIDE_W'(1);
      end
      ST_KEEP_W: begin
        div_dividend = (snap_auto || snap_sw < snap_dw) ? snap_sw : snap_dw;
        div_divisor  = {1'b0, step_x};
        half_d       = snap_dw >> 1;
      end
      ST_KEEP_H: begin
        div_dividend = (snap_auto || snap_sh < snap_dh) ? snap_sh : snap_dh;
        div_divisor  = {1'b0, step_y};
        half_d       = snap_dh >> 1;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // smallest fitting step is one more than the larger of the two quotients
  assign fit_max  = (div_quotient > fit_q) ? div_quotient : fit_q;
  assign fit_step = (fit_max == MAX_STEP) ? MAX_STEP : fit_max + SIDE_ONE;
  assign half_k   = div_quotient >> 1;
  assign centered = (half_d >= half_k) ? half_d - half_k : '0;

  dfb_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      byte_in_pixel <= '0;
      source_column <= '0;
      source_row    <= '0;
      col_phase     <= '0;
      col_quot      <= '0;
      row_phase     <= '0;
      row_quot      <= '0;
      held_bytes    <= '0;
      step_x        <= SIDE_ONE;
      step_y        <= SIDE_ONE;
      origin_x      <= '0;
      origin_y      <= '0;
      kept_columns  <= '0;
      kept_rows     <= '0;
    end else begin
      state <= state_next;

      if (start_go) begin
        byte_in_pixel <= '0;
        source_column <= '0;
        source_row    <= '0;
        col_phase     <= '0;
        col_quot      <= '0;
        row_phase     <= '0;
        row_quot      <= '0;
        held_bytes    <= '0;
        if (!cfg.auto_fit) begin
          step_x   <= (scale_x == '0) ? SIDE_ONE : scale_x;
          step_y   <= (scale_y == '0) ? SIDE_ONE : scale_y;
          origin_x <= cfg.manual_origin[SIDE_W-1:0];
          origin_y <= cfg.manual_origin[INDEX_W-1:SIDE_W];
        end
      end

      if (div_done) begin
        case (state)
          ST_FIT_H: begin
            step_x <= fit_step;
            step_y <= fit_step;
          end
          ST_KEEP_W: begin
            kept_columns <= div_quotient;
            if (snap_auto) origin_x <= centered;
          end
          ST_KEEP_H: begin
            kept_rows <= div_quotient;
            if (snap_auto) origin_y <= centered;
          end
          default: begin
          end
        endcase
      end

      if (data_go) begin
        if (byte_in_pixel == BYTE_FIRST) begin
          held_bytes <= {8'h00, item.source_byte};
        end else if (byte_in_pixel == BYTE_SECOND) begin
          held_bytes <= held_bytes | {item.source_byte, 8'h00};
        end
        if (pixel_end) begin
          byte_in_pixel <= '0;
          if (row_end) begin
            source_column <= '0;
            col_phase     <= '0;
            col_quot      <= '0;
            source_row    <= source_row + SIDE_ONE;
            if (row_phase_inc == step_y) begin
              row_phase <= '0;
              row_quot  <= row_quot + SIDE_ONE;
            end else begin
              row_phase <= row_phase_inc;
            end
          end else begin
            source_column <= col_inc[SIDE_W-1:0];
            if (col_phase_inc == step_x) begin
              col_phase <= '0;
              col_quot  <= col_quot + SIDE_ONE;
            end else begin
              col_phase <= col_phase_inc;
            end
          end
        end else begin
          byte_in_pixel <= byte_in_pixel + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_go) begin
      snap_sw   <= sw;
      snap_sh   <= sh;
      snap_dw   <= dw;
      snap_dh   <= dh;
      snap_auto <= cfg.auto_fit;
    end
    if (div_done && state == ST_FIT_W) begin
      fit_q <= div_quotient;
    end
  end

endmodule

/* sv/dfb_queue.sv */
// ----------------------------------------------------------------------------
// dfb_queue
// small register queue of pixel jobs between front and back
// ----------------------------------------------------------------------------
module dfb_queue #(
  parameter int DEPTH = dfb_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dfb_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output dfb_pkg::job_t head_job
);
  import dfb_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  job_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full       = count == CNT_W'(DEPTH);
  assign head_valid = count != '0;
  assign head_job   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_job;
  end

endmodule

/* sv/dfb_back.sv */
// ----------------------------------------------------------------------------
// dfb_back
// word index multiply and byte lane placement, two register stages
// ----------------------------------------------------------------------------
module dfb_back (
  input  logic                 clk,
  input  logic                 rst,
  input  dfb_pkg::side_t       screen_width,
  input  logic [dfb_pkg::CHANNELS*dfb_pkg::LANE_W-1:0] channel_lanes,
  input  logic                 head_valid,
  input  dfb_pkg::job_t        head_job,
  output logic                 pop,
  output logic                 pixel_valid,
  input  logic                 pixel_stall,
  output dfb_pkg::out_item_t   pixel
);
  import dfb_pkg::*;

  logic [LANES-1:0][7:0] lane_data;
  logic [LANES-1:0]      lane_en;
  logic [INDEX_W-1:0]    row_base;

  logic                  s1_valid;
  logic [INDEX_W-1:0]    s1_base;
  side_t                 s1_x;
  logic [31:0]           s1_data;
  logic [LANES-1:0]      s1_en;

  logic                  s1_load, out_load;

  // later channels win a shared lane
  always_comb begin
    lane_data = '0;
    lane_en   = '0;
    for (int k = 0; k < CHANNELS; k++) begin
      lane_data[channel_lanes[LANE_W*k +: LANE_W]] = head_job.channel[k];
      lane_en[channel_lanes[LANE_W*k +: LANE_W]]   = 1'b1;
    end
  end

  assign row_base = screen_width * head_job.y;

  assign out_load = s1_valid && (!pixel_valid || !pixel_stall);
  assign s1_load  = head_valid && (!s1_valid || out_load);
  assign pop      = s1_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      pixel_valid <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid <= 1'b1;
      end else if (out_load) begin
        s1_valid <= 1'b0;
      end
      if (out_load) begin
        pixel_valid <= 1'b1;
      end else if (!pixel_stall) begin
        pixel_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_base <= row_base;
      s1_x    <= head_job.x;
      s1_data <= lane_data;
      s1_en   <= lane_en;
    end
    if (out_load) begin
      pixel.word_index  <= s1_base + {{(INDEX_W-SIDE_W){1'b0}}, s1_x};
      pixel.write_data  <= s1_data;
      pixel.byte_enable <= s1_en;
    end
  end

endmodule

/* sv/decimating_framebuffer_blitter.sv */
// ----------------------------------------------------------------------------
// decimating_framebuffer_blitter
// raster byte stream in, decimated 32-bit framebuffer word writes out
// ----------------------------------------------------------------------------
//
//   channel   signals                          moves
//   -------   ------------------------------   -------------------------------
//   config    cfg_we, cfg_index, cfg_data      register write, no back-pressure
//   item      item_valid, item_stall, item     start command or one source byte
//   pixel     pixel_valid, pixel_stall, pixel  one framebuffer word write
//
// the front takes in a data byte at its transfer; a kept pixel is written to
// the job queue at the transfer of its third byte, then passes the multiply
// register and the add register to the pixel port, held back by pixel_stall
// a start command runs frame setup on one shared 12-step divider: four
// divisions in auto-fit mode, two in manual mode;
// item_stall stays high while frame setup runs
// item_stall also rises while the job queue is full
// synchronous reset clears the registers to their defaults and the frame
// state to "nothing kept"; no clearing pass is needed
//
module decimating_framebuffer_blitter #(
  parameter int QUEUE_DEPTH = dfb_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [dfb_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [dfb_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  dfb_pkg::in_item_t                   item,
  output logic                                pixel_valid,
  input  logic                                pixel_stall,
  output dfb_pkg::out_item_t                  pixel
);
  import dfb_pkg::*;

  cfg_t          cfg;
  front_status_t front_status;
  job_t          front_job;
  logic          queue_full;
  logic          head_valid;
  job_t          head_job;
  logic          back_pop;

  // register bank; the user must write it only while the block is idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.auto_fit        <= 1'b0;
      cfg.source_size     <= '0;
      cfg.bytes_per_pixel <= BPP_MIN;
      cfg.screen_size     <= '0;
      cfg.manual_scale    <= INDEX_W'(4097);  // unit step in both directions
      cfg.manual_origin   <= '0;
      cfg.channel_lanes   <= 6'd36;           // bytes to lanes 0, 1, 2
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_AUTO_FIT:        cfg.auto_fit        <= cfg_data[0];
        CFG_SOURCE_SIZE:     cfg.source_size     <= cfg_data[INDEX_W-1:0];
        CFG_BYTES_PER_PIXEL: cfg.bytes_per_pixel <= cfg_data[2:0];
        CFG_SCREEN_SIZE:     cfg.screen_size     <= cfg_data[INDEX_W-1:0];
        CFG_MANUAL_SCALE:    cfg.manual_scale    <= cfg_data[INDEX_W-1:0];
        CFG_MANUAL_ORIGIN:   cfg.manual_origin   <= cfg_data[INDEX_W-1:0];
        CFG_CHANNEL_LANES:   cfg.channel_lanes   <= cfg_data[CHANNELS*LANE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // front: item intake, frame setup, raster tracking, keep decision
  dfb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .queue_full (queue_full),
    .status     (front_status),
    .job        (front_job)
  );

  // decouples the byte-rate front from the output side
  dfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (front_status.push),
    .push_job   (front_job),
    .full       (queue_full),
    .pop        (back_pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // back: word index and lane placement; screen width and lanes are live
  dfb_back u_back (
    .clk           (clk),
    .rst           (rst),
    .screen_width  (cfg.screen_size[SIDE_W-1:0]),
    .channel_lanes (cfg.channel_lanes),
    .head_valid    (head_valid),
    .head_job      (head_job),
    .pop           (back_pop),
    .pixel_valid   (pixel_valid),
    .pixel_stall   (pixel_stall),
    .pixel         (pixel)
  );

  // no item transfer while frame setup runs
  a_setup_blocks_items: assert property (@(posedge clk) disable iff (rst)
    front_status.busy |-> item_stall)
    else $error("item transfer during frame setup");

  // a start transfer always enters frame setup
  a_start_enters_setup: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && item.command == CMD_START) |=> front_status.busy)
    else $error("start command did not begin frame setup");

  // the front never offers a job the queue cannot hold
  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    front_status.push |-> !queue_full)
    else $error("pixel job pushed into a full queue");

  // every word write enables at least one lane
  a_lanes_enabled: assert property (@(posedge clk) disable iff (rst)
    pixel_valid |-> (pixel.byte_enable != '0))
    else $error("pixel write with no byte lane enabled");

endmodule

/* tb/decimating_framebuffer_blitter_test.sv */
// ----------------------------------------------------------------------------
// decimating_framebuffer_blitter_test
// self-checking bench: feeds frames of source bytes and start commands,
// predicts every framebuffer word write and compares each pixel transfer
// ----------------------------------------------------------------------------
module decimating_framebuffer_blitter_test;
  import dfb_pkg::*;

  localparam int CYCLE_LIMIT  = 100000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;

  logic                   clk         = 1'b0;
  logic                   rst         = 1'b1;
  logic                   cfg_we      = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data    = '0;
  logic                   item_valid  = 1'b0;
  logic                   item_stall;
  in_item_t               item        = '0;
  logic                   pixel_valid;
  logic                   pixel_stall = 1'b0;
  out_item_t              pixel;

  // idling odds in percent, changed per phase
  int unsigned send_idle_pct = 8;
  int unsigned recv_idle_pct = 74;
  // cycles of forced receiver hold-off still to go
  int unsigned hold_left     = 0;
  int unsigned error_count   = 0;
  int unsigned cycles_run;

  // mirror of the register file
  logic        reg_auto;
  logic [23:0] reg_src, reg_scr, reg_scale, reg_org;
  logic [2:0]  reg_bpp;
  logic [5:0]  reg_lanes;

  // mirror of the frame state
  logic [1:0]  pix_byte;
  side_t       src_col, src_row, step_x, step_y, org_x, org_y, keep_cols, keep_rows;
  logic [15:0] held;

  // word writes predicted but not yet seen on the pixel port
  out_item_t   pixels_due[$];

  decimating_framebuffer_blitter dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    for (cycles_run = 0; cycles_run < CYCLE_LIMIT; cycles_run++) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic side_t centered_offset(int unsigned screen_side, int unsigned kept);
    return (screen_side / 2 >= kept / 2) ? side_t'(screen_side / 2 - kept / 2) : '0;
  endfunction

  task automatic blit_reset();
    reg_auto  = 1'b0;
    reg_src   = '0;
    reg_bpp   = BPP_MIN;
    reg_scr   = '0;
    reg_scale = {SIDE_ONE, SIDE_ONE};
    reg_org   = '0;
    reg_lanes = 6'b10_01_00;
    pix_byte  = '0;
    src_col   = '0;
    src_row   = '0;
    step_x    = SIDE_ONE;
    step_y    = SIDE_ONE;
    org_x     = '0;
    org_y     = '0;
    keep_cols = '0;
    keep_rows = '0;
    held      = '0;
  endtask

  task automatic blit_register_write(input logic [CFG_INDEX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] value);
    case (idx)
      CFG_AUTO_FIT:        reg_auto  = value[0];
      CFG_SOURCE_SIZE:     reg_src   = value;
      CFG_BYTES_PER_PIXEL: reg_bpp   = value[2:0];
      CFG_SCREEN_SIZE:     reg_scr   = value;
      CFG_MANUAL_SCALE:    reg_scale = value;
      CFG_MANUAL_ORIGIN:   reg_org   = value;
      CFG_CHANNEL_LANES:   reg_lanes = value[5:0];
      default: ;
    endcase
  endtask

  // frame setup: steps, origin and kept extent from the latched registers
  task automatic blit_start_frame();
    int unsigned sw, sh, dw, dh, f, kx, ky;
    sw = reg_src[11:0];
    sh = reg_src[23:12];
    dw = reg_scr[11:0];
    dh = reg_scr[23:12];
    if (reg_auto) begin
      // smallest equal step that fits, saturating at the largest step
      f = 1;
      while (f < MAX_STEP && (sw / f > dw || sh / f > dh)) f++;
      step_x    = side_t'(f);
      step_y    = side_t'(f);
      keep_cols = side_t'(sw / f);
      keep_rows = side_t'(sh / f);
      org_x     = centered_offset(dw, sw / f);
      org_y     = centered_offset(dh, sh / f);
    end else begin
      step_x = reg_scale[11:0];
      step_y = reg_scale[23:12];
      if (step_x == 0) step_x = SIDE_ONE;
      if (step_y == 0) step_y = SIDE_ONE;
      kx = (dw / step_x < sw / step_x) ? dw / step_x : sw / step_x;
      ky = (dh / step_y < sh / step_y) ? dh / step_y : sh / step_y;
      keep_cols = side_t'(kx);
      keep_rows = side_t'(ky);
      org_x     = reg_org[11:0];
      org_y     = reg_org[23:12];
    end
    pix_byte = '0;
    src_col  = '0;
    src_row  = '0;
    held     = '0;
  endtask

  // one source byte; a kept on-screen pixel queues its word write
  task automatic blit_source_byte(input logic [7:0] b);
    int unsigned bpp, sw, sh, dw, dh, x, y, lane, k;
    logic [7:0]  chan [CHANNELS];
    out_item_t   due;
    bpp = (reg_bpp < BPP_MIN) ? BPP_MIN : ((reg_bpp > BPP_MAX) ? BPP_MAX : reg_bpp);
    sw  = reg_src[11:0];
    sh  = reg_src[23:12];
    dw  = reg_scr[11:0];
    dh  = reg_scr[23:12];
    // past the last row everything is ignored
    if (src_row >= sh) return;
    if (pix_byte == 2'd0) begin
      held = {8'h00, b};
    end else if (pix_byte == 2'd1) begin
      held = held | {b, 8'h00};
    end else if (pix_byte == 2'd2) begin
      if (src_col % step_x == 0 && src_row % step_y == 0 &&
          src_col / step_x < keep_cols && src_row / step_y < keep_rows) begin
        x = src_col / step_x + org_x;
        y = src_row / step_y + org_y;
        if (x < dw && y < dh) begin
          chan[0] = held[7:0];
          chan[1] = held[15:8];
          chan[2] = b;
          due = '0;
          // later channel wins a shared lane
          for (k = 0; k < CHANNELS; k++) begin
            lane = reg_lanes[2*k +: 2];
            due.write_data[8*lane +: 8] = chan[k];
            due.byte_enable[lane]       = 1'b1;
          end
          due.word_index = INDEX_W'(dw * y + x);
          pixels_due.push_back(due);
        end
      end
    end
    // a fourth byte is counted but not kept; row end wraps the column
    if (pix_byte + 1 >= bpp) begin
      pix_byte = '0;
      if (src_col + 1 >= sw) begin
        src_col = '0;
        src_row = src_row + 1'b1;
      end else begin
        src_col = src_col + 1'b1;
      end
    end else begin
      pix_byte = pix_byte + 1'b1;
    end
  endtask

  // ------------------------------------------------------------ monitor, check

  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst) begin
      blit_reset();
    end else begin
      if (cfg_we) blit_register_write(cfg_index, cfg_data);
      if (item_valid && !item_stall) begin
        if (item.command == CMD_START) blit_start_frame();
        else blit_source_byte(item.source_byte);
      end
      if (pixel_valid && !pixel_stall) begin
        if (pixels_due.size() == 0) begin
          $error("pixel transfer with nothing due: word_index %0h data %0h",
                 pixel.word_index, pixel.write_data);
          error_count++;
        end else begin
          want = pixels_due.pop_front();
          if (pixel.word_index !== want.word_index) begin
            $error("word_index: expected %0h, got %0h", want.word_index, pixel.word_index);
            error_count++;
          end
          if (pixel.write_data !== want.write_data) begin
            $error("write_data: expected %0h, got %0h", want.write_data, pixel.write_data);
            error_count++;
          end
          if (pixel.byte_enable !== want.byte_enable) begin
            $error("byte_enable: expected %0h, got %0h", want.byte_enable, pixel.byte_enable);
            error_count++;
          end
        end
      end
    end
  end

  // receiver: random stall, or a long hold-off when asked
  always @(posedge clk) begin
    if (hold_left != 0) begin
      pixel_stall <= 1'b1;
      hold_left--;
    end else begin
      pixel_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // ------------------------------------------------------------------ drivers

  task automatic send_item(input logic cmd, input logic [7:0] b);
    in_item_t next;
    next.command     = cmd;
    next.source_byte = b;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= next;
    // hold until the transfer
    do @(posedge clk); while (item_stall);
  endtask

  task automatic write_reg(input cfg_index_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // all writes out, pipeline drained, frame setup finished
  task automatic wait_idle();
    item_valid <= 1'b0;
    // let the monitor take in the last transfer before looking at the queue
    @(posedge clk);
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  task automatic write_all(input logic auto_fit, input logic [23:0] src,
                           input logic [2:0] bpp, input logic [23:0] scr,
                           input logic [23:0] scale, input logic [23:0] origin,
                           input logic [5:0] lanes);
    wait_idle();
    write_reg(CFG_AUTO_FIT, {23'd0, auto_fit});
    write_reg(CFG_SOURCE_SIZE, src);
    write_reg(CFG_BYTES_PER_PIXEL, {21'd0, bpp});
    write_reg(CFG_SCREEN_SIZE, scr);
    write_reg(CFG_MANUAL_SCALE, scale);
    write_reg(CFG_MANUAL_ORIGIN, origin);
    write_reg(CFG_CHANNEL_LANES, {18'd0, lanes});
  endtask

  // -------------------------------------------------------------------- tests

  // data bytes straight out of reset keep nothing
  task automatic test_data_before_start();
    send_item(CMD_DATA, 8'h00);
    send_item(CMD_DATA, 8'hFF);
  endtask

  // 2x1 source, 4 bytes per pixel (written as 7), zero scale, second column
  // lands off screen, two bytes share lane 0, then a byte past the last row
  task automatic test_manual_edges();
    write_all(1'b0, {12'd1, 12'd2}, 3'd7, {12'd1, 12'd2}, 24'd0, {12'd0, 12'd1},
              6'b11_00_00);
    send_item(CMD_START, 8'hFF);
    send_item(CMD_DATA, 8'h00);
    send_item(CMD_DATA, 8'hFF);
    send_item(CMD_DATA, 8'h5A);
    send_item(CMD_DATA, 8'hA5);
    send_item(CMD_DATA, 8'h12);
    send_item(CMD_DATA, 8'h34);
    send_item(CMD_DATA, 8'h56);
    send_item(CMD_DATA, 8'h78);
    send_item(CMD_DATA, 8'hC3);
  endtask

  // zero source width: every pixel ends a row; bytes per pixel 0 acts as 3
  task automatic test_zero_width();
    int k;
    write_all(1'b0, {12'd2, 12'd0}, 3'd0, {12'd2, 12'd2}, {12'd1, 12'd1}, 24'd0,
              6'b00_01_10);
    send_item(CMD_START, 8'h00);
    for (k = 0; k < 9; k++) send_item(CMD_DATA, 8'($urandom));
  endtask

  // auto-fit on a zero screen never fits: step saturates, all off screen
  task automatic test_no_fit();
    write_all(1'b1, 24'hFFFFFF, 3'd3, 24'd0, 24'hFFFFFF, 24'hFFFFFF, 6'b11_11_11);
    send_item(CMD_START, 8'h00);
    send_item(CMD_DATA, 8'hFF);
    send_item(CMD_DATA, 8'h00);
    send_item(CMD_DATA, 8'hFF);
  endtask

  // direct copy of 8x4 while the receiver holds off, so the job queue fills
  // and the item port stalls
  task automatic test_backpressure();
    int k;
    write_all(1'b0, {12'd4, 12'd8}, 3'd3, {12'd4, 12'd8}, {12'd1, 12'd1}, 24'd0,
              6'($urandom));
    send_item(CMD_START, 8'h00);
    hold_left = HOLD_CYCLES;
    for (k = 0; k < 96; k++) send_item(CMD_DATA, 8'($urandom));
  endtask

  // random frames: mostly whole frames with random content, some cut short,
  // some restarted mid-stream, some trailing bytes past the last row
  task automatic test_random_frames(input int goal);
    int unsigned sw, sh, dw, dh, sx, sy, ox, oy, bpp_eff, total, n;
    logic [2:0]  bpp;
    logic [23:0] scale_word, origin_word;
    logic        fit;
    int          sent;
    sent    = 0;
    sw      = 0;
    sh      = 0;
    bpp_eff = BPP_MIN;
    while (sent < goal) begin
      if (sent == 0 || $urandom_range(3) != 0) begin
        fit = ($urandom_range(3) == 0);
        if ($urandom_range(11) == 0) begin
          sw = $urandom_range(0, 4095);
          sh = $urandom_range(1, 4095);
        end else begin
          sw = $urandom_range(0, 6);
          sh = $urandom_range(0, 5);
        end
        if ($urandom_range(7) == 0) begin
          // wide screen, far origin: high word indexes
          dw = $urandom_range(2048, 4095);
          dh = $urandom_range(2048, 4095);
          ox = $urandom_range(0, 4095);
          oy = $urandom_range(0, 4095);
        end else begin
          dw = $urandom_range(0, 8);
          dh = $urandom_range(0, 8);
          ox = $urandom_range(0, 3);
          oy = $urandom_range(0, 3);
        end
        sx = $urandom_range(0, 3);
        sy = $urandom_range(0, 3);
        scale_word  = ($urandom_range(9) == 0) ? 24'($urandom) : {12'(sy), 12'(sx)};
        origin_word = ($urandom_range(9) == 0) ? 24'($urandom) : {12'(oy), 12'(ox)};
        bpp = ($urandom_range(3) == 0) ? 3'($urandom_range(0, 7))
                                       : 3'($urandom_range(BPP_MIN, BPP_MAX));
        bpp_eff = (bpp < BPP_MIN) ? BPP_MIN : ((bpp > BPP_MAX) ? BPP_MAX : bpp);
        write_all(fit, {12'(sh), 12'(sw)}, bpp, {12'(dh), 12'(dw)}, scale_word,
                  origin_word, 6'($urandom));
      end
      send_item(CMD_START, 8'($urandom));
      sent++;
      total = sw * sh * bpp_eff;
      if (total > 90) total = $urandom_range(12, 90);
      if ($urandom_range(6) == 0) total = $urandom_range(0, total);
      for (n = 0; n < total; n++) begin
        if ($urandom_range(99) < 2) send_item(CMD_START, 8'($urandom));
        else send_item(CMD_DATA, 8'($urandom));
        sent++;
      end
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 3)) send_item(CMD_DATA, 8'($urandom));
      end
    end
  endtask

  // ------------------------------------------------------------------ sequence

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_data_before_start();
    test_manual_edges();
    test_zero_width();
    test_no_fit();

    send_idle_pct = 8;
    recv_idle_pct = 74;
    test_random_frames(215);
    test_backpressure();

    send_idle_pct = 74;
    recv_idle_pct = 8;
    test_random_frames(215);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_frames(220);

    wait_idle();
    if (error_count == 0 && pixels_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
